### hdl/nrlm_pkg.sv
// Shared types and constants for the number range list matcher.
package nrlm_pkg;

  localparam int unsigned NUMBER_BITS_DEF = 20;
  localparam int unsigned TARGET_BITS     = 20;
  localparam int unsigned CHAR_BITS       = 8;

  localparam logic [CHAR_BITS-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_BITS-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    KIND_SINGLE = 2'd0,
    KIND_COLON  = 2'd1,
    KIND_DASH   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PH_WS     = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    POS_FIRST  = 2'd0,
    POS_SECOND = 2'd1,
    POS_LATER  = 2'd2
  } pos_e;

  // Control part of a finished spec request passed from front to back.
  typedef struct packed {
    kind_e kind;
    logic  last;
  } spec_ctrl_t;

endpackage

### hdl/nrlm_front.sv
// Front end: per-character number parsing, emits one request per finished spec.
module nrlm_front #(
  parameter int unsigned NUMBER_BITS = nrlm_pkg::NUMBER_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               acc_i,
  input  logic [nrlm_pkg::CHAR_BITS-1:0]     ch_i,
  input  logic                               last_i,
  input  logic [nrlm_pkg::TARGET_BITS-1:0]   target_i,
  output logic                               push_o,
  output nrlm_pkg::spec_ctrl_t               ctrl_o,
  output logic [NUMBER_BITS:0]               lo_o,
  output logic [NUMBER_BITS:0]               hi_o,
  output logic [nrlm_pkg::TARGET_BITS-1:0]   target_o
);

  localparam int unsigned VW = NUMBER_BITS + 1;  // sign in top bit

  function automatic logic [VW+1:0] parse_step(input nrlm_pkg::phase_e ph,
                                               input logic [VW-1:0] val,
                                               input logic [nrlm_pkg::CHAR_BITS-1:0] c);
    logic                   dig;
    logic                   ws;
    logic [NUMBER_BITS-1:0] dext;
    logic [NUMBER_BITS+3:0] m;
    nrlm_pkg::phase_e       nph;
    logic [VW-1:0]          nv;
    dig  = (c >= nrlm_pkg::CH_ZERO) && (c <= nrlm_pkg::CH_NINE);
    ws   = (c == nrlm_pkg::CH_SPACE) || ((c >= nrlm_pkg::CH_TAB) && (c <= nrlm_pkg::CH_CR));
    dext = {{(NUMBER_BITS-4){1'b0}}, c[3:0]};
    m    = {1'b0, val[NUMBER_BITS-1:0], 3'b000} + {3'b000, val[NUMBER_BITS-1:0], 1'b0}
         + {{NUMBER_BITS{1'b0}}, c[3:0]};
    nph  = ph;
    nv   = val;
    case (ph)
      nrlm_pkg::PH_WS: begin
        if (ws) begin
          nph = nrlm_pkg::PH_WS;
        end else if (c == nrlm_pkg::CH_PLUS) begin
          nph = nrlm_pkg::PH_SIGN;
        end else if (c == nrlm_pkg::CH_MINUS) begin
          nph = nrlm_pkg::PH_SIGN;
          nv  = {1'b1, {NUMBER_BITS{1'b0}}};
        end else if (dig) begin
          nph = nrlm_pkg::PH_DIGITS;
          nv  = {val[NUMBER_BITS], dext};
        end else begin
          nph = nrlm_pkg::PH_DONE;
        end
      end
      nrlm_pkg::PH_SIGN: begin
        if (dig) begin
          nph = nrlm_pkg::PH_DIGITS;
          nv  = {val[NUMBER_BITS], dext};
        end else begin
          nph = nrlm_pkg::PH_DONE;
        end
      end
      nrlm_pkg::PH_DIGITS: begin
        if (dig) begin
          // saturate magnitude at all ones
          if (m[NUMBER_BITS+3:NUMBER_BITS] != 4'd0) begin
            nv = {val[NUMBER_BITS], {NUMBER_BITS{1'b1}}};
          end else begin
            nv = {val[NUMBER_BITS], m[NUMBER_BITS-1:0]};
          end
        end else begin
          nph = nrlm_pkg::PH_DONE;
        end
      end
      default: begin
        nph = nrlm_pkg::PH_DONE;
      end
    endcase
    return {nph, nv};
  endfunction

  nrlm_pkg::kind_e  kind_q, kind_d;
  nrlm_pkg::pos_e   pos_q, pos_d;
  logic [VW-1:0]    lo_q, lo_d;
  nrlm_pkg::phase_e lo_ph_q, lo_ph_d;
  logic [VW-1:0]    hi_q, hi_d;
  nrlm_pkg::phase_e hi_ph_q, hi_ph_d;
  logic             hi_run_q, hi_run_d;
  logic [VW-1:0]    fb_q, fb_d;
  nrlm_pkg::phase_e fb_ph_q, fb_ph_d;

  logic [VW+1:0] lo_r, hi_r, fb_r;
  logic          is_comma;

  // take_char results
  nrlm_pkg::kind_e  t_kind;
  nrlm_pkg::pos_e   t_pos;
  logic [VW-1:0]    t_lo, t_hi, t_fb;
  nrlm_pkg::phase_e t_lo_ph, t_hi_ph, t_fb_ph;
  logic             t_hi_run;

  // spec snapshot that gets closed
  nrlm_pkg::kind_e  s_kind;
  logic [VW-1:0]    s_lo, s_hi, s_fb;
  nrlm_pkg::phase_e s_lo_ph;
  logic             s_hi_run;

  always_comb begin
    is_comma = (ch_i == nrlm_pkg::CH_COMMA);
    lo_r     = parse_step(lo_ph_q, lo_q, ch_i);
    hi_r     = parse_step(hi_ph_q, hi_q, ch_i);
    fb_r     = parse_step(fb_ph_q, fb_q, ch_i);

    if (ch_i == nrlm_pkg::CH_COLON) begin
      t_kind = nrlm_pkg::KIND_COLON;
    end else if (ch_i == nrlm_pkg::CH_MINUS) begin
      t_kind = nrlm_pkg::KIND_DASH;
    end else begin
      t_kind = kind_q;
    end

    if (pos_q != nrlm_pkg::POS_FIRST) begin
      t_fb    = fb_r[VW-1:0];
      t_fb_ph = nrlm_pkg::phase_e'(fb_r[VW+1:VW]);
    end else begin
      t_fb    = fb_q;
      t_fb_ph = fb_ph_q;
    end

    t_hi_run = hi_run_q;
    if (hi_run_q) begin
      t_hi    = hi_r[VW-1:0];
      t_hi_ph = nrlm_pkg::phase_e'(hi_r[VW+1:VW]);
    end else begin
      t_hi    = hi_q;
      t_hi_ph = hi_ph_q;
    end

    t_lo    = lo_r[VW-1:0];
    t_lo_ph = nrlm_pkg::phase_e'(lo_r[VW+1:VW]);
    // end of low digits: the high bound begins with the next character
    if ((lo_ph_q == nrlm_pkg::PH_DIGITS) && (t_lo_ph == nrlm_pkg::PH_DONE)) begin
      t_hi_run = 1'b1;
    end

    case (pos_q)
      nrlm_pkg::POS_FIRST: t_pos = nrlm_pkg::POS_SECOND;
      default:             t_pos = nrlm_pkg::POS_LATER;
    endcase

    if (is_comma) begin
      s_kind = kind_q; s_lo = lo_q; s_hi = hi_q; s_fb = fb_q;
      s_lo_ph = lo_ph_q; s_hi_run = hi_run_q;
    end else begin
      s_kind = t_kind; s_lo = t_lo; s_hi = t_hi; s_fb = t_fb;
      s_lo_ph = t_lo_ph; s_hi_run = t_hi_run;
    end

    push_o      = acc_i && (is_comma || last_i);
    ctrl_o.kind = s_kind;
    ctrl_o.last = last_i;
    lo_o        = s_lo;
    hi_o        = ((s_lo_ph == nrlm_pkg::PH_DIGITS) || s_hi_run) ? s_hi : s_fb;
    target_o    = target_i;

    kind_d = kind_q; pos_d = pos_q; lo_d = lo_q; lo_ph_d = lo_ph_q;
    hi_d = hi_q; hi_ph_d = hi_ph_q; hi_run_d = hi_run_q; fb_d = fb_q; fb_ph_d = fb_ph_q;
    if (push_o) begin
      kind_d = nrlm_pkg::KIND_SINGLE; pos_d = nrlm_pkg::POS_FIRST;
      lo_d = '0; lo_ph_d = nrlm_pkg::PH_WS;
      hi_d = '0; hi_ph_d = nrlm_pkg::PH_WS; hi_run_d = 1'b0;
      fb_d = '0; fb_ph_d = nrlm_pkg::PH_WS;
    end else if (acc_i) begin
      kind_d = t_kind; pos_d = t_pos; lo_d = t_lo; lo_ph_d = t_lo_ph;
      hi_d = t_hi; hi_ph_d = t_hi_ph; hi_run_d = t_hi_run;
      fb_d = t_fb; fb_ph_d = t_fb_ph;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q   <= nrlm_pkg::KIND_SINGLE;
      pos_q    <= nrlm_pkg::POS_FIRST;
      lo_q     <= '0;
      lo_ph_q  <= nrlm_pkg::PH_WS;
      hi_q     <= '0;
      hi_ph_q  <= nrlm_pkg::PH_WS;
      hi_run_q <= 1'b0;
      fb_q     <= '0;
      fb_ph_q  <= nrlm_pkg::PH_WS;
    end else begin
      kind_q   <= kind_d;
      pos_q    <= pos_d;
      lo_q     <= lo_d;
      lo_ph_q  <= lo_ph_d;
      hi_q     <= hi_d;
      hi_ph_q  <= hi_ph_d;
      hi_run_q <= hi_run_d;
      fb_q     <= fb_d;
      fb_ph_q  <= fb_ph_d;
    end
  end

endmodule

### hdl/nrlm_queue.sv
// Two-entry request queue between front and back.
module nrlm_queue #(
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] push_data_i,
  output logic          full_o,
  output logic          pop_valid_o,
  input  logic          pop_i,
  output logic [DW-1:0] pop_data_o
);

  localparam int unsigned DEPTH = 2;

  logic [DW-1:0] mem_q [DEPTH];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;

  assign full_o      = (cnt_q == 2'(DEPTH));
  assign pop_valid_o = (cnt_q != 2'd0);
  assign pop_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### hdl/nrlm_back.sv
// Back end: checks each finished spec against the target and delivers the result.
module nrlm_back #(
  parameter int unsigned NUMBER_BITS = nrlm_pkg::NUMBER_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             req_valid_i,
  output logic                             req_pop_o,
  input  nrlm_pkg::spec_ctrl_t             ctrl_i,
  input  logic [NUMBER_BITS:0]             lo_i,
  input  logic [NUMBER_BITS:0]             hi_i,
  input  logic [nrlm_pkg::TARGET_BITS-1:0] target_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             is_valid_o
);

  localparam int unsigned MW = (NUMBER_BITS > nrlm_pkg::TARGET_BITS) ?
                               NUMBER_BITS : nrlm_pkg::TARGET_BITS;
  localparam int unsigned CW = MW + 2;

  function automatic logic signed [CW-1:0] to_signed(input logic [NUMBER_BITS:0] v);
    logic signed [CW-1:0] mag;
    mag = signed'({{(CW-NUMBER_BITS){1'b0}}, v[NUMBER_BITS-1:0]});
    return v[NUMBER_BITS] ? -mag : mag;
  endfunction

  logic                 matched_q, matched_d;
  logic                 out_valid_q, out_valid_d;
  logic                 is_valid_q, is_valid_d;
  logic signed [CW-1:0] lo_s, hi_s, t_s;
  logic                 in_range, hit, slot_free;

  always_comb begin
    lo_s     = to_signed(lo_i);
    hi_s     = to_signed(hi_i);
    t_s      = signed'({{(CW-nrlm_pkg::TARGET_BITS){1'b0}}, target_i});
    in_range = (t_s >= lo_s) && (t_s <= hi_s);
    case (ctrl_i.kind)
      nrlm_pkg::KIND_COLON: hit = in_range;
      // negative odd low never matches
      nrlm_pkg::KIND_DASH:  hit = !(lo_i[NUMBER_BITS] && lo_i[0])
                                  && (target_i[0] == lo_i[0]) && in_range;
      default:              hit = (t_s == lo_s);
    endcase
    hit = hit && (target_i != '0);

    slot_free = !out_valid_q || !out_stall_i;
    req_pop_o = req_valid_i && (!ctrl_i.last || slot_free);

    matched_d   = matched_q;
    out_valid_d = out_valid_q && out_stall_i;
    is_valid_d  = is_valid_q;
    if (req_pop_o) begin
      if (ctrl_i.last) begin
        out_valid_d = 1'b1;
        is_valid_d  = matched_q || hit;
        matched_d   = 1'b0;
      end else begin
        matched_d = matched_q || hit;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign is_valid_o  = is_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matched_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      matched_q   <= matched_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_valid_q <= is_valid_d;
  end

endmodule

### hdl/number_range_list_matcher.sv
// A finished spec is first registered in the spec queue; its result is then registered
// in the back end's output register once the back end pops that spec from the queue.
// Throughput: one character per cycle; the front parser takes a character each
// cycle unless the two-entry spec queue is full, which only output stall causes.
// Reset: asynchronous active low; clears parser state, queue and match flag.
// Top level of the number range list matcher.
module number_range_list_matcher #(
  parameter int unsigned NUMBER_BITS = nrlm_pkg::NUMBER_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [nrlm_pkg::CHAR_BITS-1:0]   ch_i,
  input  logic                             last_char_i,
  input  logic [nrlm_pkg::TARGET_BITS-1:0] target_number_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             is_valid_o
);

  localparam int unsigned VW = NUMBER_BITS + 1;
  localparam int unsigned CTW = $bits(nrlm_pkg::spec_ctrl_t);
  localparam int unsigned DW = CTW + 2 * VW + nrlm_pkg::TARGET_BITS;

  logic                             acc, push, full, pop_valid, pop;
  nrlm_pkg::spec_ctrl_t             f_ctrl, b_ctrl;
  logic [VW-1:0]                    f_lo, f_hi, b_lo, b_hi;
  logic [nrlm_pkg::TARGET_BITS-1:0] f_tgt, b_tgt;
  logic [DW-1:0]                    push_data, pop_data;

  assign in_stall_o = full;
  assign acc        = in_valid_i && !full;
  assign push_data  = {f_ctrl, f_lo, f_hi, f_tgt};
  assign {b_ctrl, b_lo, b_hi, b_tgt} = pop_data;

  nrlm_front #(.NUMBER_BITS(NUMBER_BITS)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (acc),
    .ch_i     (ch_i),
    .last_i   (last_char_i),
    .target_i (target_number_i),
    .push_o   (push),
    .ctrl_o   (f_ctrl),
    .lo_o     (f_lo),
    .hi_o     (f_hi),
    .target_o (f_tgt)
  );

  nrlm_queue #(.DW(DW)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_valid_o (pop_valid),
    .pop_i       (pop),
    .pop_data_o  (pop_data)
  );

  nrlm_back #(.NUMBER_BITS(NUMBER_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (pop_valid),
    .req_pop_o   (pop),
    .ctrl_i      (b_ctrl),
    .lo_i        (b_lo),
    .hi_i        (b_hi),
    .target_i    (b_tgt),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .is_valid_o  (is_valid_o)
  );

endmodule
